// ----- hdl/vfc_pkg.sv -----
// ---------------------------------------------------------------------------
// vfc_pkg
// Shared sizes, codes and payload types of the voxel face culling block.
// ---------------------------------------------------------------------------
package vfc_pkg;

    // chunk geometry and id width
    localparam int EDGE_CELLS     = 16;
    localparam int ID_BITS        = 8;
    localparam int COORD_BITS     = (EDGE_CELLS > 1) ? $clog2(EDGE_CELLS) : 1;
    localparam int PLANE_CELLS    = EDGE_CELLS * EDGE_CELLS;
    localparam int GRID_CELLS     = PLANE_CELLS * EDGE_CELLS;
    localparam int SIDE_COUNT     = 6;
    localparam int FLAG_CELLS     = SIDE_COUNT * PLANE_CELLS;
    localparam int GRID_ADDR_BITS = $clog2(GRID_CELLS);
    localparam int FLAG_ADDR_BITS = $clog2(FLAG_CELLS);

    // boundary planes and faces share one encoding
    localparam logic [2:0] SIDE_PY = 3'd0;
    localparam logic [2:0] SIDE_NY = 3'd1;
    localparam logic [2:0] SIDE_PX = 3'd2;
    localparam logic [2:0] SIDE_NX = 3'd3;
    localparam logic [2:0] SIDE_PZ = 3'd4;
    localparam logic [2:0] SIDE_NZ = 3'd5;

    typedef logic [COORD_BITS-1:0] t_coord;

    // transaction commands
    typedef enum logic [1:0] {
        CMD_WR_CELL = 2'd0,
        CMD_WR_EDGE = 2'd1,
        CMD_QUERY   = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic [3:0] cell_z;
        logic [7:0] new_id;
        logic [2:0] side;
        logic       side_is_air;
    } t_in_item;

    typedef struct packed {
        logic [3:0] out_x;
        logic [3:0] out_y;
        logic [3:0] out_z;
        logic [7:0] cell_id;
        logic [5:0] face_mask;
    } t_out_item;

    // storage access between sequencer and memories
    typedef enum logic [1:0] {
        ST_NOP     = 2'd0,
        ST_WR_CELL = 2'd1,
        ST_WR_FLAG = 2'd2,
        ST_RD      = 2'd3
    } t_store_op;

    typedef struct packed {
        t_store_op          op;
        t_coord             gx;
        t_coord             gy;
        t_coord             gz;
        logic [2:0]         side;
        t_coord             pa;
        t_coord             pb;
        logic [ID_BITS-1:0] id;
        logic               flag;
    } t_store_req;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               is_air;
        logic               flag;
    } t_store_rsp;

endpackage

// ----- hdl/vfc_store.sv -----
// ---------------------------------------------------------------------------
// vfc_store
// Cell id grid and boundary air flag planes, each a single-port memory with
// registered read data, plus the air test on the id read back.
// ---------------------------------------------------------------------------
module vfc_store
    import vfc_pkg::*;
(
    input  logic       i_clk,
    input  t_store_req i_req,
    input  logic [7:0] i_air_id,
    output t_store_rsp o_rsp
);

    // linear grid address, x fastest
    function automatic logic [GRID_ADDR_BITS-1:0] grid_addr(
        input t_coord x,
        input t_coord y,
        input t_coord z
    );
        logic [GRID_ADDR_BITS-1:0] row;
        row = GRID_ADDR_BITS'(z) * GRID_ADDR_BITS'(EDGE_CELLS) + GRID_ADDR_BITS'(y);
        return row * GRID_ADDR_BITS'(EDGE_CELLS) + GRID_ADDR_BITS'(x);
    endfunction

    // linear flag address, one plane after another
    function automatic logic [FLAG_ADDR_BITS-1:0] flag_addr(
        input logic [2:0] side,
        input t_coord     a,
        input t_coord     b
    );
        return FLAG_ADDR_BITS'(side) * FLAG_ADDR_BITS'(PLANE_CELLS)
             + FLAG_ADDR_BITS'(b) * FLAG_ADDR_BITS'(EDGE_CELLS)
             + FLAG_ADDR_BITS'(a);
    endfunction

    logic [ID_BITS-1:0]        r_cell_mem [GRID_CELLS];
    logic                      r_flag_mem [FLAG_CELLS];
    logic [ID_BITS-1:0]        r_cell_q;
    logic                      r_flag_q;
    logic [GRID_ADDR_BITS-1:0] cell_addr;
    logic [FLAG_ADDR_BITS-1:0] edge_addr;

    assign cell_addr = grid_addr(i_req.gx, i_req.gy, i_req.gz);
    assign edge_addr = flag_addr(i_req.side, i_req.pa, i_req.pb);

    // grid memory port
    always_ff @(posedge i_clk) begin
        if (i_req.op == ST_WR_CELL) begin
            r_cell_mem[cell_addr] <= i_req.id;
        end
        if (i_req.op == ST_RD) begin
            r_cell_q <= r_cell_mem[cell_addr];
        end
    end

    // boundary flag memory port
    always_ff @(posedge i_clk) begin
        if (i_req.op == ST_WR_FLAG) begin
            r_flag_mem[edge_addr] <= i_req.flag;
        end
        if (i_req.op == ST_RD) begin
            r_flag_q <= r_flag_mem[edge_addr];
        end
    end

    // read response
    assign o_rsp.id     = r_cell_q;
    assign o_rsp.is_air = (r_cell_q == ID_BITS'(i_air_id));
    assign o_rsp.flag   = r_flag_q;

endmodule

// ----- hdl/voxel_face_cull.sv -----
// ---------------------------------------------------------------------------
// voxel_face_cull
// Hidden face culling for one voxel chunk: stores cell ids and boundary air
// flags, answers a query with the cell id and its mask of exposed faces.
// ---------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-----------------------
//  in        | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out       | out       | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  cfg       | in        | i_cfg_we                   | i_cfg_data (air id)
//
//  writes are taken in the idle state; a query stalls the input from accept
//  to the next accept: seven reads of the single-port grid memory (cell, then
//  six neighbours), a drain state for the last read data, a result load state.
//  reset is synchronous, active low; memory contents are kept undefined.
//  a query waits in its last state while the previous result is stalled.
// ---------------------------------------------------------------------------
module voxel_face_cull
    import vfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_LAST   = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_step, n_step;
    logic               r_pend_valid, n_pend_valid;
    logic [2:0]         r_pend_step, n_pend_step;
    logic               r_pend_edge, n_pend_edge;
    logic [3:0]         r_x, n_x;
    logic [3:0]         r_y, n_y;
    logic [3:0]         r_z, n_z;
    logic               r_inside, n_inside;
    logic [ID_BITS-1:0] r_center, n_center;
    logic               r_center_air, n_center_air;
    logic [5:0]         r_mask, n_mask;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic [7:0]         r_air_id, n_air_id;

    logic       accept_in;
    logic       out_take;
    logic       in_inside;
    logic [2:0] face;
    logic [2:0] pend_face;
    logic       face_open;
    logic       nb_edge;
    t_coord     lx, ly, lz;
    t_coord     last;
    t_store_req req;
    t_store_rsp rsp;

    assign accept_in = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;
    assign in_inside = (32'(i_in_data.cell_x) < EDGE_CELLS)
                    && (32'(i_in_data.cell_y) < EDGE_CELLS)
                    && (32'(i_in_data.cell_z) < EDGE_CELLS);

    assign lx   = COORD_BITS'(r_x);
    assign ly   = COORD_BITS'(r_y);
    assign lz   = COORD_BITS'(r_z);
    assign last = COORD_BITS'(EDGE_CELLS - 1);
    assign face = r_step - 3'd1;

    // storage request: writes from the input, reads from the sequencer
    always_comb begin
        req         = '0;
        req.op      = ST_NOP;
        req.id      = ID_BITS'(i_in_data.new_id);
        req.flag    = i_in_data.side_is_air;
        nb_edge     = 1'b0;
        if (r_state == S_IDLE) begin
            req.gx   = COORD_BITS'(i_in_data.cell_x);
            req.gy   = COORD_BITS'(i_in_data.cell_y);
            req.gz   = COORD_BITS'(i_in_data.cell_z);
            req.side = i_in_data.side;
            case (i_in_data.side) inside
                SIDE_PY, SIDE_NY: begin
                    req.pa = COORD_BITS'(i_in_data.cell_x);
                    req.pb = COORD_BITS'(i_in_data.cell_z);
                end
                SIDE_PX, SIDE_NX: begin
                    req.pa = COORD_BITS'(i_in_data.cell_y);
                    req.pb = COORD_BITS'(i_in_data.cell_z);
                end
                default: begin
                    req.pa = COORD_BITS'(i_in_data.cell_x);
                    req.pb = COORD_BITS'(i_in_data.cell_y);
                end
            endcase
            if (accept_in && in_inside) begin
                case (i_in_data.command)
                    CMD_WR_CELL: req.op = ST_WR_CELL;
                    CMD_WR_EDGE: begin
                        if (i_in_data.side <= SIDE_NZ) begin
                            req.op = ST_WR_FLAG;
                        end
                    end
                    default: req.op = ST_NOP;
                endcase
            end
        end else if (r_state == S_READ) begin
            req.op   = ST_RD;
            req.gx   = lx;
            req.gy   = ly;
            req.gz   = lz;
            req.side = face;
            if (r_step != STEP_CENTER) begin
                case (face)
                    SIDE_PY: begin
                        nb_edge = (ly == last);
                        req.gy  = ly + t_coord'(1);
                        req.pa  = lx;
                        req.pb  = lz;
                    end
                    SIDE_NY: begin
                        nb_edge = (ly == '0);
                        req.gy  = ly - t_coord'(1);
                        req.pa  = lx;
                        req.pb  = lz;
                    end
                    SIDE_PX: begin
                        nb_edge = (lx == last);
                        req.gx  = lx + t_coord'(1);
                        req.pa  = ly;
                        req.pb  = lz;
                    end
                    SIDE_NX: begin
                        nb_edge = (lx == '0);
                        req.gx  = lx - t_coord'(1);
                        req.pa  = ly;
                        req.pb  = lz;
                    end
                    SIDE_PZ: begin
                        nb_edge = (lz == last);
                        req.gz  = lz + t_coord'(1);
                        req.pa  = lx;
                        req.pb  = ly;
                    end
                    default: begin
                        nb_edge = (lz == '0);
                        req.gz  = lz - t_coord'(1);
                        req.pa  = lx;
                        req.pb  = ly;
                    end
                endcase
            end
        end
    end

    vfc_store u_store (
        .i_clk    (i_clk),
        .i_req    (req),
        .i_air_id (r_air_id),
        .o_rsp    (rsp)
    );

    // returned read: boundary flag or neighbour air test
    assign pend_face = r_pend_step - 3'd1;
    assign face_open = r_pend_edge ? rsp.flag : rsp.is_air;

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_pend_valid = (r_state == S_READ);
        n_pend_step  = r_step;
        n_pend_edge  = nb_edge;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        n_inside     = r_inside;
        n_center     = r_center;
        n_center_air = r_center_air;
        n_mask       = r_mask;
        n_out_valid  = r_out_valid && !out_take;
        n_out        = r_out;
        n_air_id     = i_cfg_we ? i_cfg_data : r_air_id;

        // collect read data in the cycle after each read
        if (r_pend_valid) begin
            if (r_pend_step == STEP_CENTER) begin
                n_center     = rsp.id;
                n_center_air = rsp.is_air;
            end else begin
                n_mask = r_mask | (6'(face_open) << pend_face);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept_in && i_in_data.command == CMD_QUERY) begin
                    n_x      = i_in_data.cell_x;
                    n_y      = i_in_data.cell_y;
                    n_z      = i_in_data.cell_z;
                    n_inside = in_inside;
                    n_step   = STEP_CENTER;
                    n_mask   = '0;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_step = r_step + 3'd1;
                if (r_step == STEP_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || out_take) begin
                    n_out.out_x     = r_x;
                    n_out.out_y     = r_y;
                    n_out.out_z     = r_z;
                    n_out.cell_id   = r_inside ? 8'(r_center) : 8'd0;
                    n_out.face_mask = (r_inside && !r_center_air) ? r_mask : 6'd0;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= STEP_CENTER;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_air_id     <= 8'd0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_air_id     <= n_air_id;
        end
        r_pend_step  <= n_pend_step;
        r_pend_edge  <= n_pend_edge;
        r_x          <= n_x;
        r_y          <= n_y;
        r_z          <= n_z;
        r_inside     <= n_inside;
        r_center     <= n_center;
        r_center_air <= n_center_air;
        r_mask       <= n_mask;
        r_out        <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a new result only comes from the result load state
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result loaded outside the result load state");

    // an accepted query starts the read sequence at the centre cell
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_in && i_in_data.command == CMD_QUERY)
        |=> (r_state == S_READ && r_step == STEP_CENTER))
        else $error("query did not start the read sequence");

    // drain follows the last neighbour read
    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_pend_valid && r_pend_step == STEP_LAST))
        else $error("drain without the last neighbour read pending");

    // an air cell never reports exposed faces
    a_air_no_faces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.face_mask != 6'd0)
        |-> (ID_BITS'(o_out_data.cell_id) != ID_BITS'(r_air_id)))
        else $error("air cell reported exposed faces");

endmodule
